[hw/rtl/strict_priority_multi_queue_assert.svh]
// Assertion macros for the scheduler's checker.
`ifndef STRICT_PRIORITY_MULTI_QUEUE_ASSERT_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPMQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/spmq_pkg.sv]
// Types and codes shared by the strict priority multi queue.
package spmq_pkg;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef struct packed {
		logic              func;
		logic [15:0]       task_id;
		logic signed [7:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [15:0] out_task_id;
		logic        found;
		logic        accepted;
	} rsp_t;

	typedef struct packed {
		logic push_ok;
		logic pop_hit;
	} sched_stat_t;

endpackage

[hw/rtl/spmq_store.sv]
// Task identifier memory: one write or one registered read per cycle.
module spmq_store #(
	parameter int ENTRIES = 128,
	localparam int AW = $clog2(ENTRIES)
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [15:0]   wdata,
	output logic [15:0]   rdata
);

	logic [15:0] mem [ENTRIES];
	logic [15:0] rdata_q;

	// Write on push, read on pop; read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/spmq_sched.sv]
// Per-level head and count state, level selection and slot addressing.
module spmq_sched #(
	parameter int LEVELS = 8,
	parameter int DEPTH = 16,
	localparam int LW = $clog2(LEVELS),
	localparam int DW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1),
	localparam int AW = $clog2(LEVELS * DEPTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      upd,
	input  spmq_pkg::req_t            req,
	output spmq_pkg::sched_stat_t     stat,
	output logic [AW-1:0]             addr
);

	logic [DW-1:0]     head_q  [LEVELS];
	logic [CW-1:0]     count_q [LEVELS];
	logic [LEVELS-1:0] busy;
	logic [LW-1:0]     push_lv;
	logic [LW-1:0]     pop_lv;
	logic              hit;
	logic [LW-1:0]     sel_lv;
	logic [DW-1:0]     sel_head;
	logic [CW-1:0]     sel_cnt;
	logic [CW:0]       tail_sum;
	logic [DW-1:0]     slot;
	logic [DW-1:0]     head_nxt;
	logic              is_pop;

	assign is_pop = (req.func == spmq_pkg::FUNC_POP);

	// Clamp the signed priority into the level range.
	always_comb begin
		if (req.priority_req[7]) begin
			push_lv = '0;
		end else if ({1'b0, req.priority_req[6:0]} >= 8'(LEVELS)) begin
			push_lv = LW'(LEVELS - 1);
		end else begin
			push_lv = req.priority_req[LW-1:0];
		end
	end

	// Find the highest non-empty level.
	always_comb begin
		pop_lv = '0;
		hit = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			busy[i] = (count_q[i] != '0);
			if (busy[i]) begin
				pop_lv = LW'(i);
				hit = 1'b1;
			end
		end
	end

	// Select the level and compute the slot touched by this word.
	always_comb begin
		sel_lv   = is_pop ? pop_lv : push_lv;
		sel_head = head_q[sel_lv];
		sel_cnt  = count_q[sel_lv];
		tail_sum = (CW+1)'(sel_head) + (CW+1)'(sel_cnt);
		if (is_pop) begin
			slot = sel_head;
		end else if (tail_sum >= (CW+1)'(DEPTH)) begin
			slot = DW'(tail_sum - (CW+1)'(DEPTH));
		end else begin
			slot = DW'(tail_sum);
		end
		head_nxt = (sel_head == DW'(DEPTH - 1)) ? '0 : sel_head + 1'b1;
		stat.push_ok = !is_pop && (sel_cnt != CW'(DEPTH));
		stat.pop_hit = is_pop && hit;
		addr = AW'(sel_lv * DEPTH + slot);
	end

	// Advance head and count of the selected level on an accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (upd) begin
			if (stat.push_ok) begin
				count_q[sel_lv] <= sel_cnt + 1'b1;
			end else if (stat.pop_hit) begin
				count_q[sel_lv] <= sel_cnt - 1'b1;
				head_q[sel_lv]  <= head_nxt;
			end
		end
	end

endmodule

[hw/rtl/strict_priority_multi_queue.sv]
// Top level of the strict priority multi queue scheduler.
// Request channel (req_valid, req_stall, req): a push word appends task_id to
// the FIFO of its priority level, clamped to 0..LEVELS-1; a pop word takes the
// head of the highest non-empty level.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one word per request,
// in request order. A push reports accepted (0 when the level was full and the
// task dropped); a pop reports found and out_task_id (zero when nothing found).
// Timing: a push response is registered straight from the accepted word; a
// pop response waits on the pending flag, as the task memory read is registered.
// Throughput: one push per cycle while rsp_stall is low; after a pop the request
// side is held off while the memory read is in flight.
// Each level holds DEPTH entries in a shared memory of LEVELS*DEPTH words.
// Reset clears all head and count state at once, so all levels read empty
// right after reset; the memory itself needs no clearing.
// While rsp_stall is high the response word holds, and a new request is taken
// only once the pending response leaves.
module strict_priority_multi_queue #(
	parameter int LEVELS = 8,
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  spmq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output spmq_pkg::rsp_t rsp
);

	localparam int AW = $clog2(LEVELS * DEPTH);

	spmq_pkg::sched_stat_t stat;
	logic [AW-1:0]         addr;
	logic [15:0]           rdata;
	logic                  acc;
	logic                  is_pop;
	logic                  out_take;
	logic                  pend_q;
	logic                  pend_hit_q;
	logic                  out_valid_q;
	spmq_pkg::rsp_t        out_q;

	assign is_pop    = (req.func == spmq_pkg::FUNC_POP);
	assign out_take  = out_valid_q && !rsp_stall;
	assign req_stall = pend_q || (out_valid_q && rsp_stall);
	assign acc       = req_valid && !req_stall;

	spmq_sched #(
		.LEVELS(LEVELS),
		.DEPTH (DEPTH)
	) u_sched (
		.clk   (clk),
		.arst_n(arst_n),
		.upd   (acc),
		.req   (req),
		.stat  (stat),
		.addr  (addr)
	);

	spmq_store #(
		.ENTRIES(LEVELS * DEPTH)
	) u_store (
		.clk  (clk),
		.we   (acc && stat.push_ok),
		.re   (acc && stat.pop_hit),
		.addr (addr),
		.wdata(req.task_id),
		.rdata(rdata)
	);

	// Track a pop waiting on the memory read, and the response word's valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			pend_hit_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc && is_pop) begin
				pend_q     <= 1'b1;
				pend_hit_q <= stat.pop_hit;
			end else begin
				pend_q <= 1'b0;
			end
			if ((acc && !is_pop) || pend_q) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the response word: push status at once, pop data after the read.
	always_ff @(posedge clk) begin
		if (acc && !is_pop) begin
			out_q.out_task_id <= '0;
			out_q.found       <= 1'b0;
			out_q.accepted    <= stat.push_ok;
		end else if (pend_q) begin
			out_q.out_task_id <= pend_hit_q ? rdata : 16'h0000;
			out_q.found       <= pend_hit_q;
			out_q.accepted    <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

[hw/rtl/spmq_checker.sv]
// Port-level assertions for the strict priority multi queue, bound to the top.
`include "strict_priority_multi_queue_assert.svh"

module spmq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input spmq_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input spmq_pkg::rsp_t rsp
);

	logic push_acc;

	assign push_acc = req_valid && !req_stall && (req.func == spmq_pkg::FUNC_PUSH);

	// A stalled response word holds.
	`SPMQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response word changed")

	// A word never reports both a found task and a stored push.
	`SPMQ_ASSERT_NOW(a_found_excl, clk, arst_n, rsp_valid, !(rsp.found && rsp.accepted), "found and accepted both set")

	// No task identifier without a found task.
	`SPMQ_ASSERT_NOW(a_id_zero, clk, arst_n, rsp_valid && !rsp.found, rsp.out_task_id == 16'h0000, "task id nonzero without found")

	// A push response follows its acceptance in the next cycle.
	`SPMQ_ASSERT_NEXT(a_push_lat, clk, arst_n, push_acc, rsp_valid && !rsp.found, "push response missing")

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
